### hw/rtl/per_channel_plateau_tracker_defines.svh
// Assertion macros shared by the plateau tracker RTL.
`ifndef PER_CHANNEL_PLATEAU_TRACKER_DEFINES_SVH
`define PER_CHANNEL_PLATEAU_TRACKER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define PPT_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("plateau tracker: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define PPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("plateau tracker: next-cycle check failed");

`endif

### hw/rtl/ppt_pkg.sv
package ppt_pkg;

    // Default number of channels held in the store.
    localparam int CHANNELS_DEFAULT = 16;

    // The channel field is four bits wide, so at most this many channels are reachable.
    localparam int CHANNEL_FIELD_LIMIT = 16;

    localparam int HITS_W    = 16;
    localparam int DAC_W     = 8;
    localparam int CHAN_W    = 4;
    localparam int COLUMN_W  = 6;
    localparam int ROW_W     = 7;
    localparam int COUNT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // One store entry: maximum count, plateau begin and plateau end.
    localparam int ENTRY_W = HITS_W + 2 * DAC_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COLUMN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

    // Input mode codes.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef struct packed {
        logic [HITS_W-1:0] max_hits;
        logic [DAC_W-1:0]  begin_dac;
        logic [DAC_W-1:0]  end_dac;
    } t_entry;

endpackage

### hw/rtl/per_channel_plateau_tracker.sv
// Per-channel plateau tracker for a delay-DAC sweep. Each sweep sample names a channel, a
// pixel, a DAC value and a hit count; only samples from the configured target pixel on a
// channel below the active channel count take part. For every channel the block keeps the
// largest hit count seen, the DAC value where it was first reached and the last DAC value
// that matched it, all in one synchronous RAM entry. A finish transfer reads the channels
// out in order, one result per channel with the quarter-way setting and a last flag on the
// final one, and then empties the store. An ignored sample leaves the block idle; a used
// sample has its entry read and then written back, since the RAM read data is registered
// after the address is presented. A finish reads the active channels one after another
// and holds while the output side stalls. The store needs no clearing pass: one valid bit
// per entry is cleared by reset and by each finish, and an entry without it reads as zero.
// Configuration is taken at any time through the write port and should only change while
// the block is idle.
`include "per_channel_plateau_tracker_defines.svh"

module per_channel_plateau_tracker #(
    parameter int CHANNELS = ppt_pkg::CHANNELS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [ppt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppt_pkg::CFG_DATA_W-1:0] i_cfg_data,

    // Input channel.
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_mode,
    input  logic [ppt_pkg::CHAN_W-1:0]     i_channel,
    input  logic [ppt_pkg::COLUMN_W-1:0]   i_pixel_column,
    input  logic [ppt_pkg::ROW_W-1:0]      i_pixel_row,
    input  logic [ppt_pkg::DAC_W-1:0]      i_dac_value,
    input  logic [ppt_pkg::HITS_W-1:0]     i_hit_count,

    // Result channel.
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ppt_pkg::CHAN_W-1:0]     o_channel_out,
    output logic                           o_found,
    output logic [ppt_pkg::DAC_W-1:0]      o_setting,
    output logic [ppt_pkg::DAC_W-1:0]      o_plateau_begin,
    output logic [ppt_pkg::DAC_W-1:0]      o_plateau_end,
    output logic                           o_last
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channels that can actually be addressed: bounded by the store and by the field width.
    localparam int LIMIT = (CHANNELS < ppt_pkg::CHANNEL_FIELD_LIMIT) ?
                           CHANNELS : ppt_pkg::CHANNEL_FIELD_LIMIT;
    localparam logic [ppt_pkg::COUNT_W-1:0] LIMIT_CNT = ppt_pkg::COUNT_W'(LIMIT);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_UPDATE = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [ppt_pkg::COLUMN_W-1:0] r_target_column;
    logic [ppt_pkg::ROW_W-1:0]    r_target_row;
    logic [ppt_pkg::COUNT_W-1:0]  r_channel_count;

    // Per-entry valid bits; an entry that is not valid reads as all zero.
    logic [CHANNELS-1:0] r_valid, n_valid;

    // Address of the entry whose data the RAM presents, and the finish readout counter.
    logic [AW-1:0]               r_addr, n_addr;
    logic [ppt_pkg::CHAN_W-1:0]  r_k, n_k;

    // Latched sample payload.
    logic [ppt_pkg::HITS_W-1:0]  r_hits, n_hits;
    logic [ppt_pkg::DAC_W-1:0]   r_dac, n_dac;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    logic [ppt_pkg::CHAN_W-1:0]  r_out_channel, n_out_channel;
    logic                        r_out_found, n_out_found;
    logic [ppt_pkg::DAC_W-1:0]   r_out_setting, n_out_setting;
    logic [ppt_pkg::DAC_W-1:0]   r_out_begin, n_out_begin;
    logic [ppt_pkg::DAC_W-1:0]   r_out_end, n_out_end;
    logic                        r_out_last, n_out_last;

    // RAM port signals.
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_raddr;
    logic [ppt_pkg::ENTRY_W-1:0] ram_rdata;
    ppt_pkg::t_entry             wr_entry;

    logic                        in_fire, out_free, sample_used;
    logic [ppt_pkg::COUNT_W-1:0] active_cnt;
    ppt_pkg::t_entry             cur;
    logic [8:0]                  diff, quarter, set_sum;
    logic                        out_is_top;

    ppt_ram #(
        .WIDTH (ppt_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign active_cnt = (r_channel_count > LIMIT_CNT) ? LIMIT_CNT : r_channel_count;

    assign o_stall  = (r_state != S_IDLE);
    assign in_fire  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign sample_used = ({1'b0, i_channel} < active_cnt)
                       && (i_pixel_column == r_target_column)
                       && (i_pixel_row == r_target_row);

    // The entry the RAM currently presents, with never-written entries forced to zero.
    assign cur = r_valid[r_addr] ? ppt_pkg::t_entry'(ram_rdata) : '0;

    // setting = begin + (end - begin) / 4, the quotient truncated toward zero.
    assign diff    = {1'b0, cur.end_dac} - {1'b0, cur.begin_dac};
    assign quarter = {{2{diff[8]}}, diff[8:2]}
                   + ((diff[8] && (diff[1:0] != 2'b00)) ? 9'd1 : 9'd0);
    assign set_sum = {1'b0, cur.begin_dac} + quarter;

    always_comb begin
        n_state       = r_state;
        n_valid       = r_valid;
        n_addr        = r_addr;
        n_k           = r_k;
        n_hits        = r_hits;
        n_dac         = r_dac;
        n_out_valid   = r_out_valid && i_stall;
        n_out_channel = r_out_channel;
        n_out_found   = r_out_found;
        n_out_setting = r_out_setting;
        n_out_begin   = r_out_begin;
        n_out_end     = r_out_end;
        n_out_last    = r_out_last;
        ram_re        = 1'b0;
        ram_raddr     = r_addr;
        ram_we        = 1'b0;
        wr_entry      = cur;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_mode == ppt_pkg::MODE_SAMPLE) begin
                        if (sample_used) begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(i_channel);
                            n_addr    = AW'(i_channel);
                            n_hits    = i_hit_count;
                            n_dac     = i_dac_value;
                            n_state   = S_UPDATE;
                        end
                    end else if (active_cnt == '0) begin
                        // No active channels: nothing to report, the store is still emptied.
                        n_valid = '0;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_addr    = '0;
                        n_k       = '0;
                        n_state   = S_FINISH;
                    end
                end
            end
            S_UPDATE: begin
                // A higher count restarts the plateau; an equal count extends it.
                if (r_hits > cur.max_hits) begin
                    ram_we             = 1'b1;
                    wr_entry.max_hits  = r_hits;
                    wr_entry.begin_dac = r_dac;
                    wr_entry.end_dac   = r_dac;
                end else if (r_hits == cur.max_hits) begin
                    ram_we           = 1'b1;
                    wr_entry.end_dac = r_dac;
                end
                if (ram_we) begin
                    n_valid[r_addr] = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_FINISH: begin
                // The RAM data stays put while the result register is full.
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_channel = r_k;
                    n_out_found   = (cur.end_dac != '0);
                    n_out_setting = (cur.end_dac != '0) ? set_sum[7:0] : '0;
                    n_out_begin   = cur.begin_dac;
                    n_out_end     = cur.end_dac;
                    n_out_last    = ({1'b0, r_k} + 5'd1 == active_cnt);
                    if ({1'b0, r_k} + 5'd1 == active_cnt) begin
                        n_valid = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k       = r_k + 4'd1;
                        ram_re    = 1'b1;
                        ram_raddr = AW'(r_k + 4'd1);
                        n_addr    = AW'(r_k + 4'd1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_valid         <= '0;
            r_out_valid     <= 1'b0;
            r_addr          <= '0;
            r_k             <= '0;
            r_target_column <= '0;
            r_target_row    <= '0;
            r_channel_count <= 5'd16;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_addr      <= n_addr;
            r_k         <= n_k;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ppt_pkg::REG_TARGET_COLUMN: begin
                        r_target_column <= i_cfg_data[ppt_pkg::COLUMN_W-1:0];
                    end
                    ppt_pkg::REG_TARGET_ROW: begin
                        r_target_row <= i_cfg_data[ppt_pkg::ROW_W-1:0];
                    end
                    ppt_pkg::REG_CHANNEL_COUNT: begin
                        r_channel_count <= i_cfg_data[ppt_pkg::COUNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_hits        <= n_hits;
        r_dac         <= n_dac;
        r_out_channel <= n_out_channel;
        r_out_found   <= n_out_found;
        r_out_setting <= n_out_setting;
        r_out_begin   <= n_out_begin;
        r_out_end     <= n_out_end;
        r_out_last    <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_channel_out   = r_out_channel;
    assign o_found         = r_out_found;
    assign o_setting       = r_out_setting;
    assign o_plateau_begin = r_out_begin;
    assign o_plateau_end   = r_out_end;
    assign o_last          = r_out_last;

    // True when the held result describes the highest active channel.
    assign out_is_top = ({1'b0, r_out_channel} + 5'd1 == active_cnt);

    // The update state always hands back to idle in the next cycle, so the next sample sees the write.
    `PPT_ASSERT_NEXT(a_update_one_cycle, i_clk, i_rst_n, r_state == S_UPDATE, r_state == S_IDLE)

    // The readout counter never walks past the active channels.
    `PPT_ASSERT_NOW(a_finish_in_range, i_clk, i_rst_n, r_state == S_FINISH, {1'b0, r_k} < active_cnt)

    // A result flagged last always describes the highest active channel.
    `PPT_ASSERT_NOW(a_last_is_top, i_clk, i_rst_n, r_out_valid && r_out_last, out_is_top)

    // After a finish run ends, the store is empty.
    `PPT_ASSERT_NEXT(a_finish_clears, i_clk, i_rst_n, r_state == S_FINISH && n_state == S_IDLE, r_valid == '0)

endmodule

### hw/rtl/ppt_ram.sv
module ppt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the per-channel plateau tracker.
//
// Sweep samples and finish transfers are sent through the input channel while a
// predictor, kept in step with every accepted transfer, holds its own copy of the
// per-channel maximum, plateau begin and plateau end. Each finish queues one
// expected result per active channel. A checking process compares every accepted
// result with the oldest one waiting. Both sides insert random gaps unless they are
// switched off. Configuration is only rewritten once the block has gone quiet.
module tb;

    localparam int LANES           = ppt_pkg::CHANNELS_DEFAULT;
    localparam int PLATEAU_DIVISOR = 4;
    // A finish walks every channel once, and a used sample reads and then writes back its
    // entry, so this is comfortably beyond the longest internal activity.
    localparam int SETTLE_CYCLES   = 2 * LANES + 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SWEEP_ROUNDS    = 12;
    localparam int ROUND_SAMPLES   = 23;
    // Results still outstanding never exceed one finish run plus the one held.
    localparam int EXPECT_DEPTH    = 64;

    typedef struct packed {
        logic [ppt_pkg::CHAN_W-1:0] chan;
        logic                       found;
        logic [ppt_pkg::DAC_W-1:0]  setting;
        logic [ppt_pkg::DAC_W-1:0]  start_dac;
        logic [ppt_pkg::DAC_W-1:0]  stop_dac;
        logic                       is_last;
    } t_plateau;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ppt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [ppt_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic                           i_mode;
    logic [ppt_pkg::CHAN_W-1:0]     i_channel;
    logic [ppt_pkg::COLUMN_W-1:0]   i_pixel_column;
    logic [ppt_pkg::ROW_W-1:0]      i_pixel_row;
    logic [ppt_pkg::DAC_W-1:0]      i_dac_value;
    logic [ppt_pkg::HITS_W-1:0]     i_hit_count;
    logic                           o_valid;
    logic                           i_stall;
    logic [ppt_pkg::CHAN_W-1:0]     o_channel_out;
    logic                           o_found;
    logic [ppt_pkg::DAC_W-1:0]      o_setting;
    logic [ppt_pkg::DAC_W-1:0]      o_plateau_begin;
    logic [ppt_pkg::DAC_W-1:0]      o_plateau_end;
    logic                           o_last;

    per_channel_plateau_tracker #(
        .CHANNELS(LANES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_mode(i_mode),
        .i_channel(i_channel),
        .i_pixel_column(i_pixel_column),
        .i_pixel_row(i_pixel_row),
        .i_dac_value(i_dac_value),
        .i_hit_count(i_hit_count),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_channel_out(o_channel_out),
        .o_found(o_found),
        .o_setting(o_setting),
        .o_plateau_begin(o_plateau_begin),
        .o_plateau_end(o_plateau_end),
        .o_last(o_last)
    );

    // Predictor state: one entry per channel plus the three configuration registers.
    logic [ppt_pkg::HITS_W-1:0]   peak_hits  [LANES];
    logic [ppt_pkg::DAC_W-1:0]    peak_start [LANES];
    logic [ppt_pkg::DAC_W-1:0]    peak_stop  [LANES];
    logic [ppt_pkg::COLUMN_W-1:0] want_column;
    logic [ppt_pkg::ROW_W-1:0]    want_row;
    logic [ppt_pkg::COUNT_W-1:0]  lane_count;

    // Expected results, kept in a ring in the order they must arrive.
    t_plateau expected_plateaus [EXPECT_DEPTH];
    int       expect_head = 0;
    int       expect_tail = 0;
    t_plateau oldest_plateau;
    int       mismatches = 0;
    int       cycles = 0;

    // Gaps on either side can be switched off to give stretches of full rate.
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int free_run = 0;
    int stall_run = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Result-side stall: short free runs broken by stalls, about one in ten of them a long one.
    always @(posedge i_clk) begin
        if (!stalls_on) begin
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            i_stall <= 1'b1;
            stall_run = stall_run - 1;
        end else if (free_run > 0) begin
            i_stall <= 1'b0;
            free_run = free_run - 1;
        end else begin
            i_stall <= 1'b0;
            free_run = $urandom_range(0, 8);
            stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
    end

    // Channels at or above the count are ignored; the count saturates at what the
    // store holds and at what the four-bit channel field can reach.
    function automatic int live_lanes();
        int n;
        n = int'(lane_count);
        if (n > LANES) n = LANES;
        if (n > ppt_pkg::CHANNEL_FIELD_LIMIT) n = ppt_pkg::CHANNEL_FIELD_LIMIT;
        return n;
    endfunction

    function automatic void clear_plateaus();
        for (int k = 0; k < LANES; k++) begin
            peak_hits[k] = '0;
            peak_start[k] = '0;
            peak_stop[k] = '0;
        end
    endfunction

    function automatic void queue_plateau(t_plateau r);
        expected_plateaus[expect_tail % EXPECT_DEPTH] = r;
        expect_tail++;
    endfunction

    function automatic void track_sample(logic [ppt_pkg::CHAN_W-1:0] ch,
            logic [ppt_pkg::COLUMN_W-1:0] col, logic [ppt_pkg::ROW_W-1:0] row,
            logic [ppt_pkg::DAC_W-1:0] dac, logic [ppt_pkg::HITS_W-1:0] hits);
        if (int'(ch) < live_lanes() && col == want_column && row == want_row) begin
            if (hits > peak_hits[ch]) begin
                peak_hits[ch] = hits;
                peak_start[ch] = dac;
            end
            // An equal count only moves the end, which also covers a count of zero
            // while the channel has seen no hits at all.
            if (hits == peak_hits[ch]) peak_stop[ch] = dac;
        end
    endfunction

    // A finish reports every active channel in order and then empties the store.
    function automatic void report_plateaus();
        int n;
        int b;
        int e;
        int s;
        t_plateau r;
        n = live_lanes();
        for (int k = 0; k < n; k++) begin
            b = int'(peak_start[k]);
            e = int'(peak_stop[k]);
            // The division truncates toward zero, so an end below the begin gives
            // a setting between the two.
            s = b + (e - b) / PLATEAU_DIVISOR;
            r.chan = k[ppt_pkg::CHAN_W-1:0];
            r.found = (e > 0);
            r.setting = r.found ? s[ppt_pkg::DAC_W-1:0] : '0;
            r.start_dac = peak_start[k];
            r.stop_dac = peak_stop[k];
            r.is_last = (k == n - 1);
            queue_plateau(r);
        end
        clear_plateaus();
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expect_head == expect_tail) begin
                $display("%0t ns: result for channel %0d arrived with nothing expected",
                         $time, o_channel_out);
                mismatches++;
            end else begin
                oldest_plateau = expected_plateaus[expect_head % EXPECT_DEPTH];
                expect_head++;
                check_field("channel", 8'(oldest_plateau.chan), 8'(o_channel_out));
                check_field("found", 8'(oldest_plateau.found), 8'(o_found));
                check_field("setting", oldest_plateau.setting, o_setting);
                check_field("plateau begin", oldest_plateau.start_dac, o_plateau_begin);
                check_field("plateau end", oldest_plateau.stop_dac, o_plateau_end);
                check_field("last", 8'(oldest_plateau.is_last), 8'(o_last));
            end
        end
    end

    // Sends one item. Valid is left high after the transfer so that back-to-back
    // items keep it high; it is only lowered at the start of a gap or while waiting for idle.
    task automatic send_item(logic mode, logic [ppt_pkg::CHAN_W-1:0] ch,
            logic [ppt_pkg::COLUMN_W-1:0] col, logic [ppt_pkg::ROW_W-1:0] row,
            logic [ppt_pkg::DAC_W-1:0] dac, logic [ppt_pkg::HITS_W-1:0] hits);
        int gap;
        int roll;
        gap = 0;
        if (gaps_on) begin
            roll = $urandom_range(0, 99);
            if (roll >= 92) gap = $urandom_range(8, 30);
            else if (roll >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_channel <= ch;
        i_pixel_column <= col;
        i_pixel_row <= row;
        i_dac_value <= dac;
        i_hit_count <= hits;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (mode == ppt_pkg::MODE_FINISH) report_plateaus();
        else track_sample(ch, col, row, dac, hits);
    endtask

    // The other fields of a finish are ignored, so they carry random values.
    task automatic finish_scan();
        send_item(ppt_pkg::MODE_FINISH, ppt_pkg::CHAN_W'($urandom),
                  ppt_pkg::COLUMN_W'($urandom), ppt_pkg::ROW_W'($urandom),
                  ppt_pkg::DAC_W'($urandom), ppt_pkg::HITS_W'($urandom));
    endtask

    // Holds the sender off until every expected result has been seen, then lets
    // a sample that produces no result finish its write-back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expect_head != expect_tail) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [ppt_pkg::COLUMN_W-1:0] col,
            logic [ppt_pkg::ROW_W-1:0] row, logic [ppt_pkg::COUNT_W-1:0] count);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= ppt_pkg::REG_TARGET_COLUMN;
        i_cfg_data <= ppt_pkg::CFG_DATA_W'(col);
        @(posedge i_clk);
        i_cfg_index <= ppt_pkg::REG_TARGET_ROW;
        i_cfg_data <= row;
        @(posedge i_clk);
        i_cfg_index <= ppt_pkg::REG_CHANNEL_COUNT;
        i_cfg_data <= ppt_pkg::CFG_DATA_W'(count);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        want_column = col;
        want_row = row;
        lane_count = count;
    endtask

    // Straight after reset every channel is empty: no plateau, all fields zero.
    task automatic test_reset_state();
        finish_scan();
    endtask

    // The update rules on hand-picked sweeps with the reset target pixel (0, 0).
    task automatic test_plateau_rules();
        // Zero hits on an untouched channel still move the end.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd0, 6'd0, 7'd0, 8'd7, 16'd0);
        // A plateau of two points followed by a lower count.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd1, 6'd0, 7'd0, 8'd10, 16'd100);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd1, 6'd0, 7'd0, 8'd20, 16'd100);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd1, 6'd0, 7'd0, 8'd30, 16'd50);
        // Unordered sweep leaving the end below the begin.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd2, 6'd0, 7'd0, 8'd200, 16'd500);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd2, 6'd0, 7'd0, 8'd40, 16'd500);
        // Full-scale count whose plateau ends at DAC zero, so nothing is found.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd3, 6'd0, 7'd0, 8'd255, 16'hFFFF);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd3, 6'd0, 7'd0, 8'd0, 16'hFFFF);
        // Samples from neighbouring pixels must leave the channel alone.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd4, 6'd1, 7'd0, 8'd90, 16'd10);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd4, 6'd0, 7'd1, 8'd91, 16'd11);
        // A rising count restarts the plateau; a dip does not touch it.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd5, 6'd0, 7'd0, 8'd1, 16'd1);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd5, 6'd0, 7'd0, 8'd2, 16'd3);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd5, 6'd0, 7'd0, 8'd3, 16'd2);
        // Highest channel at the top of both ranges.
        send_item(ppt_pkg::MODE_SAMPLE, 4'd15, 6'd0, 7'd0, 8'd255, 16'hFFFF);
        finish_scan();
    endtask

    // Channel count at its extremes, with the target pixel at its far corner.
    task automatic test_channel_limit();
        configure(6'd51, 7'd79, 5'd1);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd0, 6'd51, 7'd79, 8'd128, 16'd77);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd1, 6'd51, 7'd79, 8'd129, 16'd78);
        finish_scan();
        // With no active channel a finish reports nothing but still clears.
        configure(6'd51, 7'd79, 5'd0);
        send_item(ppt_pkg::MODE_SAMPLE, 4'd0, 6'd51, 7'd79, 8'd60, 16'd5);
        finish_scan();
        // A count above the channel field saturates; the store must be empty.
        configure(6'd0, 7'd0, 5'd31);
        finish_scan();
    endtask

    // Rounds of sweeps with random content. Each channel gets a plateau level for
    // the round so that equal counts, and with them plateau ends, come often.
    task automatic test_random_sweeps();
        logic [ppt_pkg::HITS_W-1:0]   level [LANES];
        logic [ppt_pkg::COLUMN_W-1:0] col;
        logic [ppt_pkg::ROW_W-1:0]    row;
        logic [ppt_pkg::HITS_W-1:0]   hits;
        logic [ppt_pkg::CHAN_W-1:0]   ch;
        int                           n;
        int                           pick;
        for (int round = 0; round < SWEEP_ROUNDS; round++) begin
            pick = $urandom_range(0, 99);
            configure(ppt_pkg::COLUMN_W'($urandom_range(0, 51)),
                      ppt_pkg::ROW_W'($urandom_range(0, 79)),
                      ppt_pkg::COUNT_W'(pick < 70 ? $urandom_range(1, 16)
                                        : (pick < 85 ? 16 : $urandom_range(17, 31))));
            gaps_on = (round % 4 != 1);
            stalls_on = (round % 4 != 2);
            n = live_lanes();
            for (int k = 0; k < LANES; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) level[k] = '0;
                else if (pick == 2) level[k] = 16'hFFFF;
                else level[k] = ppt_pkg::HITS_W'($urandom_range(1, 65535));
            end
            for (int item = 0; item < ROUND_SAMPLES; item++) begin
                pick = $urandom_range(0, 99);
                if (round == SWEEP_ROUNDS / 2 && item == ROUND_SAMPLES / 2) begin
                    // Report mid-sweep and hold the sender until it has all come out.
                    finish_scan();
                    wait_idle();
                end else if (pick < 4) begin
                    finish_scan();
                end else begin
                    ch = ppt_pkg::CHAN_W'((pick < 84 && n > 0) ? $urandom_range(0, n - 1)
                                                               : $urandom_range(0, 15));
                    col = want_column;
                    row = want_row;
                    pick = $urandom_range(0, 99);
                    if (pick < 8) begin
                        col = ppt_pkg::COLUMN_W'($urandom_range(0, 63));
                        row = ppt_pkg::ROW_W'($urandom_range(0, 127));
                    end else if (pick < 12) begin
                        row = ppt_pkg::ROW_W'($urandom_range(0, 127));
                    end else if (pick < 15) begin
                        col = ppt_pkg::COLUMN_W'($urandom_range(0, 63));
                    end
                    pick = $urandom_range(0, 99);
                    if (pick < 45) hits = level[ch];
                    else if (pick < 70) hits = ppt_pkg::HITS_W'($urandom_range(0, level[ch]));
                    else if (pick < 85) hits = ppt_pkg::HITS_W'($urandom);
                    else if (pick < 92) hits = '0;
                    else hits = level[ch] + 16'd1;
                    send_item(ppt_pkg::MODE_SAMPLE, ch, col, row,
                              ppt_pkg::DAC_W'($urandom_range(0, 255)), hits);
                end
            end
            finish_scan();
        end
        gaps_on = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= ppt_pkg::REG_TARGET_COLUMN;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_mode <= ppt_pkg::MODE_SAMPLE;
        i_channel <= '0;
        i_pixel_column <= '0;
        i_pixel_row <= '0;
        i_dac_value <= '0;
        i_hit_count <= '0;
        i_stall <= 1'b0;
        clear_plateaus();
        want_column = '0;
        want_row = '0;
        lane_count = 5'd16;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_plateau_rules();
        test_channel_limit();
        test_random_sweeps();

        wait_idle();
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
